// ===== src/aorr_pkg.sv =====
// ============================================================================
// aorr_pkg: shared definitions for the access order run length recorder
// Holds parameter defaults, the register reset value and the request and
// result codes.
// ============================================================================
package aorr_pkg;

	localparam int THREADS_DEF   = 64;
	localparam int SLOTS_DEF     = 256;
	localparam int LOG_PAIRS_DEF = 16384;

	// Reset value of the shared variable count register.
	localparam logic [7:0] SVC_RESET = 8'd254;

	// Register word index as decoded from paddr[2].
	localparam logic REG_SVC = 1'b0;

	typedef enum logic [1:0] {
		ACT_VAR  = 2'd0,
		ACT_SYNC = 2'd1,
		ACT_FORK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_NEW    = 2'd0,
		ST_EXTEND = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADVAR = 2'd3
	} status_t;

endpackage

// ===== src/aorr_ram.sv =====
// ============================================================================
// aorr_ram: simple dual-port synchronous RAM
// One write port and one read port with registered, enabled read data.
// ============================================================================
module aorr_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/access_order_run_length_recorder.sv =====
// Pipeline: a request is registered in stage 1, and its result in the result register.
// Throughput: one request per cycle while the result channel does not stall;
// the slot counter and run entry memories are read at acceptance and written
// back from stage 1 with forwarding. Reset: asynchronous, active low;
// afterwards a clearing pass zeroes the counter and pair count memories over
// every entry address; no request is accepted until it ends.
// ============================================================================
// access_order_run_length_recorder: run length recorder of access order
// Every slot keeps a global order counter; each (thread, slot) entry keeps
// its pair count and last run, and each recorded request yields the pair to
// write to an external log.
// ============================================================================
module access_order_run_length_recorder #(
	parameter int THREADS   = aorr_pkg::THREADS_DEF,
	parameter int SLOTS     = aorr_pkg::SLOTS_DEF,
	parameter int LOG_PAIRS = aorr_pkg::LOG_PAIRS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [5:0]  thread_id,
	input  logic [7:0]  var_index,
	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  out_thread,
	output logic [7:0]  out_slot,
	output logic [13:0] pair_index,
	output logic [31:0] run_start,
	output logic [31:0] run_count,
	output logic [1:0]  status
);

	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int SLOT_DEPTH = 1 << SLOT_W;
	localparam int THR_W      = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int ENT_W      = THR_W + SLOT_W;
	localparam int ENT_DEPTH  = THREADS * SLOT_DEPTH;
	localparam int PC_W       = $clog2(LOG_PAIRS + 1);
	localparam int CMP_W      = (SLOT_W > 8) ? SLOT_W : 8;
	localparam int PI_W       = (PC_W > 14) ? PC_W : 14;

	// ------------------------------------------------------------------
	// Configuration register. The user must write it only while the block is
	// idle (the block does not enforce this), so the slot decode below reads it freely.
	// ------------------------------------------------------------------
	logic [7:0] svc_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svc_q <= aorr_pkg::SVC_RESET;
		end else if (cfg_wr && paddr[2] == aorr_pkg::REG_SVC) begin
			svc_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == aorr_pkg::REG_SVC) ? {24'd0, svc_q} : 32'd0;

	// ------------------------------------------------------------------
	// Clearing pass after reset. The sweep covers every entry address; the
	// counter memory is cleared through the low address bits in the same
	// sweep, so it is covered many times over.
	// ------------------------------------------------------------------
	logic             clr_done_q;
	logic [ENT_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_done_q <= 1'b0;
			clr_addr_q <= '0;
		end else if (!clr_done_q) begin
			if (clr_addr_q == ENT_W'(ENT_DEPTH - 1)) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_addr_q <= clr_addr_q + ENT_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Slot decode at the request port. The effective variable count is the
	// register clipped to SLOTS-2; the sync slot follows the variables and
	// the fork slot follows the sync slot.
	// ------------------------------------------------------------------
	aorr_pkg::action_t act_in;
	logic [CMP_W-1:0]  cfg_ext;
	logic [CMP_W-1:0]  nv_lim;
	logic [CMP_W-1:0]  nvars;
	logic [CMP_W-1:0]  var_ext;
	logic [CMP_W-1:0]  slot_w;
	logic              bad_in;
	logic              thr_ok_in;
	logic [7:0]        thr8;
	logic [SLOT_W-1:0] slot_in;
	logic [ENT_W-1:0]  ent_in;
	logic              accept;

	assign act_in  = aorr_pkg::action_t'(action);
	assign cfg_ext = CMP_W'(svc_q);
	assign nv_lim  = CMP_W'(SLOTS - 2);
	assign nvars   = (cfg_ext > nv_lim) ? nv_lim : cfg_ext;
	assign var_ext = CMP_W'(var_index);
	assign bad_in  = (act_in == aorr_pkg::ACT_VAR) && (var_ext >= nvars);

	always_comb begin
		unique case (act_in)
			aorr_pkg::ACT_VAR:  slot_w = var_ext;
			aorr_pkg::ACT_SYNC: slot_w = nvars;
			aorr_pkg::ACT_FORK: slot_w = nvars + CMP_W'(1);
			aorr_pkg::ACT_NONE: slot_w = nvars + CMP_W'(1);
		endcase
	end

	assign thr8      = 8'(thread_id);
	assign thr_ok_in = 9'(thread_id) < 9'(THREADS);
	assign slot_in   = slot_w[SLOT_W-1:0];
	assign ent_in    = {thr8[THR_W-1:0], slot_in};
	assign accept    = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Stage 1 register: the decoded request, alongside the memory read data.
	// ------------------------------------------------------------------
	logic              s1_v;
	aorr_pkg::action_t act_s1;
	logic [5:0]        thr_s1;
	logic              thr_ok_s1;
	logic              bad_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [7:0]        oslot_s1;
	logic [ENT_W-1:0]  ent_s1;
	logic              s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= act_in;
			thr_s1    <= thread_id;
			thr_ok_s1 <= thr_ok_in;
			bad_s1    <= bad_in;
			slot_s1   <= slot_in;
			oslot_s1  <= slot_w[7:0];
			ent_s1    <= ent_in;
		end
	end

	// ------------------------------------------------------------------
	// Memories: slot order counters, per-entry pair counts and last runs.
	// The last run read data is only used where the pair count is nonzero, so
	// it needs no clearing.
	// ------------------------------------------------------------------
	logic              oc_we;
	logic              pc_we;
	logic              run_we;
	logic [31:0]       oc_rd;
	logic [PC_W-1:0]   pc_rd;
	logic [63:0]       run_rd;
	logic [31:0]       oc_wdata;
	logic [PC_W-1:0]   pc_wdata;
	logic [63:0]       run_wdata;

	aorr_ram #(.W(32), .DEPTH(SLOT_DEPTH), .AW(SLOT_W)) u_oc_ram (
		.clk   (clk),
		.we    (!clr_done_q || oc_we),
		.waddr (clr_done_q ? slot_s1 : clr_addr_q[SLOT_W-1:0]),
		.wdata (clr_done_q ? oc_wdata : 32'd0),
		.re    (accept),
		.raddr (slot_in),
		.rdata (oc_rd)
	);

	aorr_ram #(.W(PC_W), .DEPTH(ENT_DEPTH), .AW(ENT_W)) u_pc_ram (
		.clk   (clk),
		.we    (!clr_done_q || pc_we),
		.waddr (clr_done_q ? ent_s1 : clr_addr_q),
		.wdata (clr_done_q ? pc_wdata : PC_W'(0)),
		.re    (accept),
		.raddr (ent_in),
		.rdata (pc_rd)
	);

	aorr_ram #(.W(64), .DEPTH(ENT_DEPTH), .AW(ENT_W)) u_run_ram (
		.clk   (clk),
		.we    (run_we),
		.waddr (ent_s1),
		.wdata (run_wdata),
		.re    (accept),
		.raddr (ent_in),
		.rdata (run_rd)
	);

	// ------------------------------------------------------------------
	// Forwarding registers. A request accepted at the same edge as the
	// previous write-back reads stale memory data; these registers hold the
	// most recent write to each memory, which always agrees with memory, so
	// a hit on them is correct whether or not the memory caught up already.
	// ------------------------------------------------------------------
	logic              ocb_v_q;
	logic [SLOT_W-1:0] ocb_addr_q;
	logic [31:0]       ocb_data_q;
	logic              entb_v_q;
	logic [ENT_W-1:0]  entb_addr_q;
	logic [PC_W-1:0]   entb_pc_q;
	logic [31:0]       entb_start_q;
	logic [31:0]       entb_cnt_q;

	// ------------------------------------------------------------------
	// Stage 1 logic: continue the last run, open a new pair, or report a full table or a bad variable.
	// ------------------------------------------------------------------
	logic              started_q;
	logic              started_eff;
	logic              live;
	logic              rec;
	logic              out_free;
	logic              ent_hit;
	logic [31:0]       value;
	logic [PC_W-1:0]   n;
	logic [31:0]       st;
	logic [31:0]       cnt;
	logic [31:0]       cnt_inc;
	logic              extend;
	logic              full;
	logic              out_valid_q;
	aorr_pkg::status_t res_status;
	logic [PI_W-1:0]   res_pidx;
	logic [31:0]       res_start;
	logic [31:0]       res_count;

	assign started_eff = started_q || (act_s1 == aorr_pkg::ACT_FORK);
	assign live        = s1_v && (act_s1 != aorr_pkg::ACT_NONE) && thr_ok_s1 && started_eff;
	assign rec         = live && !bad_s1;
	assign out_free    = !out_valid_q || out_ready;
	assign s1_adv      = s1_v && (!live || out_free);
	assign in_ready    = clr_done_q && (!s1_v || s1_adv);

	assign value   = (ocb_v_q && ocb_addr_q == slot_s1) ? ocb_data_q : oc_rd;
	assign ent_hit = entb_v_q && (entb_addr_q == ent_s1);
	assign n       = ent_hit ? entb_pc_q : pc_rd;
	assign st      = ent_hit ? entb_start_q : run_rd[63:32];
	assign cnt     = ent_hit ? entb_cnt_q : run_rd[31:0];
	assign cnt_inc = cnt + 32'd1;

	// The continuation test wraps modulo 2**32; a saturated run never grows.
	assign extend = (n != '0) && (cnt != '1) && ((st + cnt) == value);
	assign full   = n >= PC_W'(LOG_PAIRS);

	assign oc_we     = s1_adv && rec;
	assign pc_we     = s1_adv && rec && !extend && !full;
	assign run_we    = s1_adv && rec && (extend || !full);
	assign oc_wdata  = value + 32'd1;
	assign pc_wdata  = n + PC_W'(1);
	assign run_wdata = extend ? {st, cnt_inc} : {value, 32'd1};

	always_comb begin
		priority if (bad_s1) begin
			res_status = aorr_pkg::ST_BADVAR;
			res_pidx   = '0;
			res_start  = 32'd0;
			res_count  = 32'd0;
		end else if (extend) begin
			res_status = aorr_pkg::ST_EXTEND;
			res_pidx   = PI_W'(n - PC_W'(1));
			res_start  = st;
			res_count  = cnt_inc;
		end else if (full) begin
			res_status = aorr_pkg::ST_FULL;
			res_pidx   = '0;
			res_start  = value;
			res_count  = 32'd1;
		end else begin
			res_status = aorr_pkg::ST_NEW;
			res_pidx   = PI_W'(n);
			res_start  = value;
			res_count  = 32'd1;
		end
	end

	// Recording starts with the first fork from a thread in range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (s1_adv && thr_ok_s1 && act_s1 == aorr_pkg::ACT_FORK) begin
			started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocb_v_q  <= 1'b0;
			entb_v_q <= 1'b0;
		end else begin
			if (oc_we) begin
				ocb_v_q <= 1'b1;
			end
			if (run_we) begin
				entb_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oc_we) begin
			ocb_addr_q <= slot_s1;
			ocb_data_q <= oc_wdata;
		end
		if (run_we) begin
			entb_addr_q  <= ent_s1;
			entb_pc_q    <= extend ? n : pc_wdata;
			entb_start_q <= run_wdata[63:32];
			entb_cnt_q   <= run_wdata[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic [5:0]        out_thread_q;
	logic [7:0]        out_slot_q;
	logic [13:0]       pair_index_q;
	logic [31:0]       run_start_q;
	logic [31:0]       run_count_q;
	aorr_pkg::status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && live) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && live) begin
			out_thread_q <= thr_s1;
			out_slot_q   <= oslot_s1;
			pair_index_q <= res_pidx[13:0];
			run_start_q  <= res_start;
			run_count_q  <= res_count;
			status_q     <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_thread = out_thread_q;
	assign out_slot   = out_slot_q;
	assign pair_index = pair_index_q;
	assign run_start  = run_start_q;
	assign run_count  = run_count_q;
	assign status     = status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !in_ready)
		else $error("request channel ready during the clearing pass");

	a_fwd_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ocb_v_q || entb_v_q) |-> clr_done_q)
		else $error("write-back seen before the clearing pass finished");

	a_new_pair_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == aorr_pkg::ST_NEW) |-> (run_count_q == 32'd1))
		else $error("new pair result without a run count of one");

	a_badvar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == aorr_pkg::ST_BADVAR)
			|-> (run_count_q == 32'd0 && pair_index_q == 14'd0))
		else $error("bad variable result carries a pair");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !s1_adv) |=> (s1_v && $stable(ent_s1)))
		else $error("stalled stage lost its request");

endmodule

// ===== test/run_log_checker.sv =====
// ============================================================================
// run_log_checker: result checker for the access order run length recorder
// Follows every accepted request and configuration write, predicts the log
// write that the recorder should produce, and compares each accepted result
// field by field against the oldest predicted write.
// ============================================================================
module run_log_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [5:0]  thread_id,
	input  logic [7:0]  var_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  out_thread,
	input  logic [7:0]  out_slot,
	input  logic [13:0] pair_index,
	input  logic [31:0] run_start,
	input  logic [31:0] run_count,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int THREADS   = aorr_pkg::THREADS_DEF;
	localparam int SLOTS     = aorr_pkg::SLOTS_DEF;
	localparam int LOG_PAIRS = aorr_pkg::LOG_PAIRS_DEF;
	localparam int ENTRIES   = THREADS * SLOTS;

	typedef struct packed {
		logic [5:0]        thr;
		logic [7:0]        slot;
		logic [13:0]       idx;
		logic [31:0]       start;
		logic [31:0]       count;
		aorr_pkg::status_t st;
	} log_write_t;

	logic [7:0]  svc_reg;
	bit          rec_on;
	logic [31:0] slot_order [SLOTS];
	int unsigned pairs_used [ENTRIES];
	logic [31:0] run_base [ENTRIES];
	logic [31:0] run_len [ENTRIES];
	log_write_t  log_writes_due [$];

	initial fail_count = 0;

	task automatic flag(input string what);
		fail_count++;
		if (fail_count <= 100)
			$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Applies one request to the shadow state and queues the log write it causes.
	function automatic void record_access(input logic [1:0] act_bits,
			input logic [5:0] thr, input logic [7:0] vidx);
		aorr_pkg::action_t act;
		int unsigned       nvars;
		int unsigned       slot;
		int unsigned       e;
		logic [31:0]       taken;
		log_write_t        w;
		act = aorr_pkg::action_t'(act_bits);
		if (act == aorr_pkg::ACT_NONE)
			return;
		if (act == aorr_pkg::ACT_FORK)
			rec_on = 1'b1;
		if (!rec_on)
			return;
		nvars = (svc_reg > SLOTS - 2) ? SLOTS - 2 : svc_reg;
		if (act == aorr_pkg::ACT_VAR && vidx >= nvars) begin
			w = '{thr: thr, slot: vidx, idx: 14'd0, start: 32'd0, count: 32'd0,
				st: aorr_pkg::ST_BADVAR};
			log_writes_due.push_back(w);
			return;
		end
		case (act)
			aorr_pkg::ACT_VAR:  slot = vidx;
			aorr_pkg::ACT_SYNC: slot = nvars;
			default:            slot = nvars + 1;
		endcase
		taken = slot_order[slot];
		slot_order[slot] = taken + 32'd1;
		e = thr * SLOTS + slot;
		if (pairs_used[e] > 0 && run_len[e] != 32'hFFFF_FFFF &&
				run_base[e] + run_len[e] == taken) begin
			run_len[e] = run_len[e] + 32'd1;
			w = '{thr: thr, slot: 8'(slot), idx: 14'(pairs_used[e] - 1),
				start: run_base[e], count: run_len[e], st: aorr_pkg::ST_EXTEND};
		end else if (pairs_used[e] >= LOG_PAIRS) begin
			w = '{thr: thr, slot: 8'(slot), idx: 14'd0, start: taken, count: 32'd1,
				st: aorr_pkg::ST_FULL};
		end else begin
			run_base[e] = taken;
			run_len[e] = 32'd1;
			w = '{thr: thr, slot: 8'(slot), idx: 14'(pairs_used[e]), start: taken,
				count: 32'd1, st: aorr_pkg::ST_NEW};
			pairs_used[e] = pairs_used[e] + 1;
		end
		log_writes_due.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		log_write_t w;
		if (!arst_n) begin
			svc_reg = aorr_pkg::SVC_RESET;
			rec_on = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				slot_order[i] = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				pairs_used[i] = 0;
				run_base[i] = '0;
				run_len[i] = '0;
			end
			log_writes_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr[2] == aorr_pkg::REG_SVC) begin
				if (pwrite)
					svc_reg = pwdata[7:0];
				else
					check_field("register readback", prdata, {24'd0, svc_reg});
			end
			if (in_valid && in_ready)
				record_access(action, thread_id, var_index);
			if (out_valid === 1'b1 && out_ready) begin
				if (log_writes_due.size() == 0) begin
					flag("result arrived with no log write predicted");
				end else begin
					w = log_writes_due.pop_front();
					check_field("out_thread", out_thread, w.thr);
					check_field("out_slot", out_slot, w.slot);
					check_field("pair_index", pair_index, w.idx);
					check_field("run_start", run_start, w.start);
					check_field("run_count", run_count, w.count);
					check_field("status", status, w.st);
				end
			end
			pending <= log_writes_due.size();
		end
	end

endmodule

// ===== test/tb_access_order_run_length_recorder.sv =====
// ============================================================================
// tb_access_order_run_length_recorder: testbench of the run length recorder
// Drives directed and random request streams through several settings of the
// shared variable count, runs a gapless stream of new pairs, and lets a
// separate checker predict and compare every log write.
// ============================================================================
module tb_access_order_run_length_recorder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] SVC_ADDR = {aorr_pkg::REG_SVC, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic [5:0]  thread_id = '0;
	logic [7:0]  var_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  out_thread;
	logic [7:0]  out_slot;
	logic [13:0] pair_index;
	logic [31:0] run_start;
	logic [31:0] run_count;
	logic [1:0]  status;
	int          fail_count;
	int          pending;

	// Sender and receiver control shared between the processes below.
	bit tx_busy = 1'b0;
	bit no_gaps = 1'b0;
	bit rx_open = 1'b0;
	int burst_left = 0;
	int hold_cycles = 0;
	int counted = 0;

	// A handful of threads that most requests come from, so that runs build up.
	logic [5:0] hot_thr [5] = '{6'd0, 6'd1, 6'd5, 6'd9, 6'd63};

	always #6 clk = ~clk;

	access_order_run_length_recorder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.thread_id  (thread_id),
		.var_index  (var_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_thread (out_thread),
		.out_slot   (out_slot),
		.pair_index (pair_index),
		.run_start  (run_start),
		.run_count  (run_count),
		.status     (status)
	);

	run_log_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.thread_id  (thread_id),
		.var_index  (var_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_thread (out_thread),
		.out_slot   (out_slot),
		.pair_index (pair_index),
		.run_start  (run_start),
		.run_count  (run_count),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// The run is cut off here if the block hangs. Well above the slowest
	// correct run, which includes the clearing pass after reset and the
	// long receiver hold-off.
	initial begin
		#(15_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver. Normally it follows a short ready pattern that is redrawn at
	// random intervals, sometimes all ones; rx_open holds ready high. A hold-off
	// request from the stimulus keeps ready low as long as it asks, counted here.
	initial begin : receiver
		logic [15:0] pat;
		int pos;
		int age;
		pat = '1;
		pos = 0;
		age = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (rx_open) begin
				out_ready <= 1'b1;
			end else begin
				if (age == 0) begin
					pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
					if (pat == 16'h0000)
						pat = 16'h8001;
					age = $urandom_range(16, 64);
				end
				out_ready <= pat[pos];
				pos = (pos + 1) % 16;
				age = age - 1;
			end
		end
	end

	// Register write: a setup phase, then the access phase that completes
	// at the edge where pready is seen high, then an idle phase. Upper data
	// bits are random since the register only keeps the low byte.
	task automatic cfg_write(input logic [7:0] val);
		logic [31:0] hi;
		hi = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SVC_ADDR;
		pwdata <= {hi[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register read; the checker compares prdata at the access edge.
	task automatic cfg_read();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= SVC_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request and returns at its acceptance edge, or after the gap.
	// Without no_gaps requests go out in bursts; after a burst valid drops for
	// a random gap. Within a burst valid stays high and only the payload moves.
	task automatic offer(input aorr_pkg::action_t act, input logic [5:0] thr,
			input logic [7:0] vidx);
		action <= act;
		thread_id <= thr;
		var_index <= vidx;
		in_valid <= 1'b1;
		tx_busy = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (act != aorr_pkg::ACT_NONE)
			counted++;
		if (!no_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				tx_busy = 1'b0;
				repeat (($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) :
						$urandom_range(1, 4))
					@(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) :
					$urandom_range(0, 11);
			end
		end
	endtask

	// Stops offering and waits until every predicted log write has come back,
	// then waits on in case an ignored request is still in flight.
	task automatic drain();
		if (tx_busy) begin
			in_valid <= 1'b0;
			tx_busy = 1'b0;
		end
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// One random phase at a given register setting. Most of it is runs of the
	// same thread touching the same slot back to back, which is what makes
	// runs extend; the rest is noise over the full range of every field.
	task automatic random_phase(input int n_req, input logic [7:0] svc, input bit pressure);
		int nvars;
		int run_n;
		int target;
		int r;
		bit paused;
		logic [5:0] thr;
		logic [7:0] vsel;
		aorr_pkg::action_t act;
		drain();
		cfg_write(svc);
		cfg_read();
		nvars = (svc > 8'd254) ? 254 : svc;
		target = counted + n_req;
		paused = 1'b0;
		// Long receiver hold-off while requests keep coming, so the block
		// backs up and stalls its request side.
		if (pressure)
			hold_cycles = 300;
		while (counted < target) begin
			// Midway through the pressure phase the sender pauses until the
			// block has handed back everything.
			if (pressure && !paused && counted >= target - n_req / 2) begin
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				thr = ($urandom_range(0, 4) != 0) ? hot_thr[$urandom_range(0, 4)] :
					6'($urandom_range(0, 63));
				r = $urandom_range(0, 99);
				act = (r < 70) ? aorr_pkg::ACT_VAR :
					(r < 85) ? aorr_pkg::ACT_SYNC : aorr_pkg::ACT_FORK;
				if (nvars == 0)
					vsel = 8'($urandom_range(0, 3));
				else if ($urandom_range(0, 9) == 0)
					vsel = 8'($urandom_range(nvars, 255));
				else if ($urandom_range(0, 3) == 0)
					vsel = 8'(nvars - 1);
				else
					vsel = 8'($urandom_range(0, ((nvars < 8) ? nvars : 8) - 1));
				run_n = $urandom_range(1, 6);
				repeat (run_n)
					offer(act, thr, vsel);
			end else begin
				offer(aorr_pkg::action_t'($urandom_range(0, 3)),
					6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register must read back its reset value. Requests offered now
		// wait out the clearing pass that follows reset.
		cfg_read();

		// Before the first fork nothing is recorded, whatever the request.
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd0);
		offer(aorr_pkg::ACT_SYNC, 6'd1, 8'd0);
		offer(aorr_pkg::ACT_NONE, 6'd0, 8'd0);
		// The first fork starts recording and is itself recorded.
		offer(aorr_pkg::ACT_FORK, 6'd63, 8'd255);
		// New pair, extension, another thread breaking the run, new pair.
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd0);
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd0);
		offer(aorr_pkg::ACT_VAR, 6'd1, 8'd0);
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd0);
		// Highest valid variable, then indexes at and above the count.
		offer(aorr_pkg::ACT_VAR, 6'd63, 8'd253);
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd254);
		offer(aorr_pkg::ACT_VAR, 6'd0, 8'd255);
		// Synchronization run, an unused action code, another fork.
		offer(aorr_pkg::ACT_SYNC, 6'd0, 8'd0);
		offer(aorr_pkg::ACT_SYNC, 6'd0, 8'd7);
		offer(aorr_pkg::ACT_NONE, 6'd5, 8'd5);
		offer(aorr_pkg::ACT_FORK, 6'd0, 8'd0);

		// With no ordinary variables every access is a bad index, and the
		// sync and fork slots move down to 0 and 1.
		drain();
		cfg_write(8'd0);
		cfg_read();
		offer(aorr_pkg::ACT_VAR, 6'd2, 8'd0);
		offer(aorr_pkg::ACT_SYNC, 6'd2, 8'd0);
		offer(aorr_pkg::ACT_FORK, 6'd2, 8'd0);
		offer(aorr_pkg::ACT_SYNC, 6'd2, 8'd0);

		// A count above the slot limit is kept but used as the limit.
		drain();
		cfg_write(8'd255);
		cfg_read();
		offer(aorr_pkg::ACT_SYNC, 6'd3, 8'd0);
		offer(aorr_pkg::ACT_VAR, 6'd3, 8'd254);
		offer(aorr_pkg::ACT_VAR, 6'd3, 8'd253);
		offer(aorr_pkg::ACT_FORK, 6'd3, 8'd0);

		random_phase(100, 8'd3, 1'b1);
		random_phase(100, 8'd254, 1'b0);
		random_phase(100, 8'd255, 1'b0);
		random_phase(100, 8'd1, 1'b0);
		random_phase(100, 8'($urandom_range(1, 254)), 1'b0);
		random_phase(100, 8'd0, 1'b0);

		// Two threads take turns on one variable with no gaps and an open
		// receiver, so every request opens a new pair while the previous
		// write-back is still landing; the last two open and then extend a run.
		drain();
		cfg_write(8'd8);
		rx_open = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 16; i++) begin
			offer(aorr_pkg::ACT_VAR, 6'd5, 8'd3);
			offer(aorr_pkg::ACT_VAR, 6'd9, 8'd3);
		end
		offer(aorr_pkg::ACT_VAR, 6'd5, 8'd3);
		offer(aorr_pkg::ACT_VAR, 6'd5, 8'd3);
		drain();
		rx_open = 1'b0;
		no_gaps = 1'b0;

		// A last mixed phase at the same setting.
		random_phase(100, 8'd8, 1'b0);

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
